>>> sv/dcr_pkg.sv
`default_nettype none
package dcr_pkg;

   localparam int CHANNEL_COUNT = 7;
   localparam int CH_W = 3;

   localparam logic [31:0] CC_WRITE_MASK = 32'h7177_0703;
   localparam logic [31:0] IW_WRITE_MASK = 32'h00FF_803F;
   localparam logic [31:0] IW_RESET_MASK = 32'h7F00_0000;
   localparam logic [31:0] PRIO_RESET    = 32'h0765_4321;
   localparam logic [31:0] UNMAPPED_DATA = 32'hFFFF_FFFF;
   localparam logic [23:0] ADDR_MASK     = 24'hFF_FFFF;
   localparam logic [23:0] WORD_ALIGN    = 24'hFF_FFFC;
   localparam logic [23:0] RAM_MASK_RESET = 24'h1F_FFFC;
   localparam logic [CH_W-1:0] OTC_CHANNEL = 3'd6;
   localparam int BUSY_POS    = 24;
   localparam int TRIGGER_POS = 28;

   localparam logic [1:0] CMD_READ   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_LEVEL  = 2'd2;
   localparam logic [1:0] CMD_FINISH = 2'd3;

   typedef enum logic [2:0] {
      OP_NONE, OP_READ, OP_WRITE, OP_LEVEL, OP_FINISH
   } op_type;

   typedef enum logic [2:0] {
      TGT_NONE, TGT_BASE, TGT_BLOCK, TGT_CHAN, TGT_PRIO, TGT_IRQ
   } tgt_type;

   localparam logic [3:0] NIB_BASE  = 4'h0;
   localparam logic [3:0] NIB_BLOCK = 4'h4;
   localparam logic [3:0] NIB_CHAN  = 4'h8;
   localparam logic [6:0] OFF_PRIO  = 7'h70;
   localparam logic [6:0] OFF_IRQ   = 7'h74;

   localparam logic [1:0] MODE_REQUEST = 2'd1;
   localparam logic [1:0] MODE_LIST    = 2'd2;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_START = 1'b1;

   typedef struct packed {
      op_type           op;
      tgt_type          tgt;
      logic [CH_W-1:0]  ch;
      logic [31:0]      value;
      logic             level;
      logic [23:0]      end_address;
      logic [15:0]      blocks_left;
      logic             finished;
   } entry_type;

   typedef struct packed {
      logic             kind;
      logic [31:0]      read_data;
      logic [CH_W-1:0]  start_channel;
      logic [23:0]      start_address;
      logic             to_device;
      logic             step_reverse;
      logic [1:0]       xfer_mode;
      logic [16:0]      block_words;
      logic [16:0]      block_total;
      logic             irq_out;
      logic             last;
   } result_type;

   function automatic logic [16:0] decode_count(input logic [15:0] v);
      return (v == 16'd0) ? 17'h10000 : {1'b0, v};
   endfunction

   function automatic logic [31:0] irq_with_master(input logic [31:0] w);
      logic [31:0] r;
      r = w;
      r[31] = w[23] & (|(w[22:16] & w[30:24]));
      return r;
   endfunction

   function automatic logic [31:0] irq_write(input logic [31:0] w, input logic [31:0] v);
      logic [31:0] r;
      r = (w & ~IW_WRITE_MASK) | (v & IW_WRITE_MASK);
      r = r & ~(v & IW_RESET_MASK);
      return irq_with_master(r);
   endfunction

   function automatic logic [CH_W-1:0] lowest_idx(input logic [CHANNEL_COUNT-1:0] m);
      logic [CH_W-1:0] r;
      r = '0;
      for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
         if (m[i]) r = CH_W'(i);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> sv/dcr_front.sv
`default_nettype none
module dcr_front
   import dcr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [6:0]  req_reg_offset,
   input  wire logic [31:0] req_write_value,
   input  wire logic [2:0]  req_channel,
   input  wire logic        req_request_level,
   input  wire logic [23:0] req_end_address,
   input  wire logic [15:0] req_blocks_left,
   input  wire logic        req_finished,
   output logic             q_valid,
   output entry_type        q_entry,
   input  wire logic        q_pop
);

   entry_type       slot_ff [2];
   entry_type       slot_in;
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   entry_type       cls;
   logic            push;
   logic            pop;
   logic [CH_W-1:0] off_ch;

   // classify the incoming word
   always_comb begin
      off_ch = req_reg_offset[6:4];
      cls.value = req_write_value;
      cls.level = req_request_level;
      cls.end_address = req_end_address;
      cls.blocks_left = req_blocks_left;
      cls.finished = req_finished;
      cls.tgt = TGT_NONE;
      cls.ch = off_ch;
      if (off_ch < CH_W'(CHANNEL_COUNT)) begin
         unique case (req_reg_offset[3:0])
            NIB_BASE:  cls.tgt = TGT_BASE;
            NIB_BLOCK: cls.tgt = TGT_BLOCK;
            NIB_CHAN:  cls.tgt = TGT_CHAN;
            default:   cls.tgt = TGT_NONE;
         endcase
      end else if (req_reg_offset == OFF_PRIO) begin
         cls.tgt = TGT_PRIO;
      end else if (req_reg_offset == OFF_IRQ) begin
         cls.tgt = TGT_IRQ;
      end
      unique case (req_command)
         CMD_READ:  cls.op = OP_READ;
         CMD_WRITE: cls.op = (cls.tgt == TGT_NONE) ? OP_NONE : OP_WRITE;
         CMD_LEVEL: begin
            cls.ch = req_channel;
            cls.op = (req_channel < CH_W'(CHANNEL_COUNT)) ? OP_LEVEL : OP_NONE;
         end
         default: begin
            cls.ch = req_channel;
            cls.op = (req_channel < CH_W'(CHANNEL_COUNT)) ? OP_FINISH : OP_NONE;
         end
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign pop = q_pop && (count_ff != 2'd0);
   assign q_valid = (count_ff != 2'd0);
   assign q_entry = slot_ff[rd_ptr_ff];
   assign slot_in = cls;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= slot_in;
   end

endmodule
`default_nettype wire

>>> sv/dcr_back.sv
`default_nettype none
module dcr_back
   import dcr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire entry_type   q_entry,
   output logic             q_pop,
   input  wire logic        csr_we,
   input  wire logic [23:0] csr_wdata,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output result_type       rsp_data
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_START = 2'd3;

   logic [1:0]               state_ff, state_in;
   entry_type                cur_ff, cur_in;
   logic [CHANNEL_COUNT-1:0] mask_ff, mask_in;
   logic [23:0]              base_ff [CHANNEL_COUNT];
   logic [23:0]              base_in [CHANNEL_COUNT];
   logic [31:0]              blk_ff [CHANNEL_COUNT];
   logic [31:0]              blk_in [CHANNEL_COUNT];
   logic [31:0]              cc_ff [CHANNEL_COUNT];
   logic [31:0]              cc_in [CHANNEL_COUNT];
   logic [CHANNEL_COUNT-1:0] dreq_ff, dreq_in;
   logic [CHANNEL_COUNT-1:0] infl_ff, infl_in;
   logic [31:0]              prio_ff, prio_in;
   logic [31:0]              irq_ff, irq_in;
   logic [23:0]              ram_mask_ff, ram_mask_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_ff, rsp_in;
   logic [CHANNEL_COUNT-1:0] elig;
   logic                     out_free;
   logic                     rsp_load;
   logic [CH_W-1:0]          sel;
   logic [CH_W-1:0]          idx;
   logic [31:0]              cc_new;
   logic [1:0]               mode;
   logic [31:0]              rd_val;

   always_comb begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
         elig[i] = prio_ff[i * 4 + 3] & cc_ff[i][BUSY_POS] & dreq_ff[i] & ~infl_ff[i];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign sel = lowest_idx(mask_ff);
   assign idx = (state_ff == S_START) ? sel : cur_ff.ch;
   assign mode = cc_ff[idx][10:9];

   always_comb begin
      unique case (cur_ff.tgt)
         TGT_BASE:  rd_val = {8'd0, base_ff[idx]};
         TGT_BLOCK: rd_val = blk_ff[idx];
         TGT_CHAN:  rd_val = cc_ff[idx];
         TGT_PRIO:  rd_val = prio_ff;
         TGT_IRQ:   rd_val = irq_ff;
         default:   rd_val = UNMAPPED_DATA;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      mask_in = mask_ff;
      base_in = base_ff;
      blk_in = blk_ff;
      cc_in = cc_ff;
      dreq_in = dreq_ff;
      infl_in = infl_ff;
      prio_in = prio_ff;
      irq_in = irq_ff;
      ram_mask_in = csr_we ? (csr_wdata & ADDR_MASK) : ram_mask_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      rsp_load = 1'b0;
      q_pop = 1'b0;
      cc_new = (cc_ff[idx] & ~CC_WRITE_MASK) | (cur_ff.value & CC_WRITE_MASK);
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cur_in = q_entry;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            mask_in = '0;
            state_in = S_IDLE;
            unique case (cur_ff.op)
               OP_READ: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     rsp_in = '0;
                     rsp_in.kind = KIND_READ;
                     rsp_in.read_data = rd_val;
                     rsp_in.irq_out = irq_ff[31];
                     rsp_in.last = 1'b1;
                  end else begin
                     state_in = S_EXEC;
                  end
               end
               OP_WRITE: begin
                  unique case (cur_ff.tgt)
                     TGT_BASE:  base_in[idx] = cur_ff.value[23:0];
                     TGT_BLOCK: blk_in[idx] = cur_ff.value;
                     TGT_CHAN: begin
                        cc_in[idx] = cc_new;
                        if (idx == OTC_CHANNEL) dreq_in[idx] = cc_new[TRIGGER_POS];
                        mask_in[idx] = 1'b1;
                        state_in = S_SCAN;
                     end
                     TGT_PRIO: begin
                        prio_in = cur_ff.value;
                        mask_in = '1;
                        state_in = S_SCAN;
                     end
                     TGT_IRQ:   irq_in = irq_write(irq_ff, cur_ff.value);
                     default:   ;
                  endcase
               end
               OP_LEVEL: begin
                  if (dreq_ff[idx] != cur_ff.level) begin
                     dreq_in[idx] = cur_ff.level;
                     mask_in[idx] = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               OP_FINISH: begin
                  if (infl_ff[idx]) begin
                     infl_in[idx] = 1'b0;
                     if (mode == MODE_REQUEST || mode == MODE_LIST) begin
                        base_in[idx] = cur_ff.end_address;
                     end
                     if (mode == MODE_REQUEST) begin
                        blk_in[idx] = {cur_ff.blocks_left, blk_ff[idx][15:0]};
                     end
                     if (cur_ff.finished) begin
                        cc_in[idx][BUSY_POS] = 1'b0;
                        if (irq_ff[16 + 32'(idx)]) begin
                           irq_in[24 + 32'(idx)] = 1'b1;
                           irq_in = irq_with_master(irq_in);
                        end
                     end
                     mask_in[idx] = 1'b1;
                     state_in = S_SCAN;
                  end
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            mask_in = mask_ff & elig;
            state_in = ((mask_ff & elig) != '0) ? S_START : S_IDLE;
         end
         default: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in.kind = KIND_START;
               rsp_in.read_data = '0;
               rsp_in.start_channel = sel;
               rsp_in.start_address = base_ff[sel] & ram_mask_ff & WORD_ALIGN;
               rsp_in.to_device = cc_ff[sel][0];
               rsp_in.step_reverse = cc_ff[sel][1];
               rsp_in.xfer_mode = mode;
               rsp_in.block_words = decode_count(blk_ff[sel][15:0]);
               rsp_in.block_total = (mode == MODE_REQUEST) ?
                                    decode_count(blk_ff[sel][31:16]) : 17'd1;
               rsp_in.irq_out = irq_ff[31];
               cc_in[sel][TRIGGER_POS] = 1'b0;
               infl_in[sel] = 1'b1;
               mask_in[sel] = 1'b0;
               rsp_in.last = (mask_in == '0);
               if (mask_in == '0) state_in = S_IDLE;
            end
         end
      endcase
      if (rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mask_ff <= '0;
         dreq_ff <= '0;
         infl_ff <= '0;
         prio_ff <= PRIO_RESET;
         irq_ff <= '0;
         ram_mask_ff <= RAM_MASK_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            base_ff[i] <= '0;
            blk_ff[i] <= '0;
            cc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         mask_ff <= mask_in;
         dreq_ff <= dreq_in;
         infl_ff <= infl_in;
         prio_ff <= prio_in;
         irq_ff <= irq_in;
         ram_mask_ff <= ram_mask_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff <= base_in;
         blk_ff <= blk_in;
         cc_ff <= cc_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_start_only: assert property (@(posedge clock) disable iff (reset)
      ((infl_ff & ~$past(infl_ff)) != '0) |-> ($past(state_ff) == S_START))
      else $error("channel marked in flight outside a start");

   a_mask_elig: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_START) |-> ((mask_ff & ~elig) == '0))
      else $error("pending start on an ineligible channel");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_in.last) |=> (state_ff == S_IDLE))
      else $error("last word sent but back end still busy");

   a_master: assert property (@(posedge clock) disable iff (reset)
      irq_ff[31] == (irq_ff[23] & (|(irq_ff[22:16] & irq_ff[30:24]))))
      else $error("master interrupt flag out of step");

endmodule
`default_nettype wire

>>> sv/dma_channel_register_control_unit.sv
// register and control side of a seven-channel dma controller
// req channel: one word per command (register read, register write,
//   device request level, transfer finished report)
// rsp channel: one word per register read and one per channel start;
//   rsp_last marks the final word caused by a command, many commands give none
// csr port: csr_we with csr_wdata writes the ram address mask, no wait
// a two-entry queue parts the decoder from the execution engine
// flow: a command is stored in the queue, then taken into the engine's command
//   register and executed in the exec state, which loads a read word into the
//   output register; commands that may start channels pass the scan state, and
//   the start state then loads one start word per started channel
// the engine's single-command state machine takes no new command until it has
//   finished the last one; a priority write can start up to 7 channels
// reset: channel and irq registers clear, priority 0x07654321, mask 0x1FFFFC
// stall: the output register holds its word while rsp_ready is low; the engine
//   waits, the queue fills, then req_ready drops
`default_nettype none
module dma_channel_register_control_unit
   import dcr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [6:0]  req_reg_offset,
   input  wire logic [31:0] req_write_value,
   input  wire logic [2:0]  req_channel,
   input  wire logic        req_request_level,
   input  wire logic [23:0] req_end_address,
   input  wire logic [15:0] req_blocks_left,
   input  wire logic        req_finished,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [31:0]      rsp_read_data,
   output logic [2:0]       rsp_start_channel,
   output logic [23:0]      rsp_start_address,
   output logic             rsp_to_device,
   output logic             rsp_step_reverse,
   output logic [1:0]       rsp_xfer_mode,
   output logic [16:0]      rsp_block_words,
   output logic [16:0]      rsp_block_total,
   output logic             rsp_irq_out,
   output logic             rsp_last,
   input  wire logic        csr_we,
   input  wire logic [23:0] csr_wdata
);

   logic       q_valid;
   logic       q_pop;
   entry_type  q_entry;
   result_type rsp_data;

   dcr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_reg_offset    (req_reg_offset),
      .req_write_value   (req_write_value),
      .req_channel       (req_channel),
      .req_request_level (req_request_level),
      .req_end_address   (req_end_address),
      .req_blocks_left   (req_blocks_left),
      .req_finished      (req_finished),
      .q_valid           (q_valid),
      .q_entry           (q_entry),
      .q_pop             (q_pop)
   );

   dcr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind = rsp_data.kind;
   assign rsp_read_data = rsp_data.read_data;
   assign rsp_start_channel = rsp_data.start_channel;
   assign rsp_start_address = rsp_data.start_address;
   assign rsp_to_device = rsp_data.to_device;
   assign rsp_step_reverse = rsp_data.step_reverse;
   assign rsp_xfer_mode = rsp_data.xfer_mode;
   assign rsp_block_words = rsp_data.block_words;
   assign rsp_block_total = rsp_data.block_total;
   assign rsp_irq_out = rsp_data.irq_out;
   assign rsp_last = rsp_data.last;

endmodule
`default_nettype wire
